[rtl/core/bpa_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// buddy page allocator core. No dependencies.
package bpa_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int POOL_W    = PAGE_W + 1;
    localparam int LVL_N     = 11;
    localparam int LVL_W     = 4;
    localparam int CNT_W     = 11;
    localparam int SUM_W     = CNT_W + LVL_N;
    localparam int CNT_MAX   = 2047;
    localparam int OUT_MAX   = 2047;
    localparam int TOP_RST   = 10;
    localparam int CFG_W     = 11;

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_POPULATE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_LEVEL = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    localparam logic CFG_TOP  = 1'b0;
    localparam logic CFG_POOL = 1'b1;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_ERR_LV,
        CMD_ERR_IDX,
        CMD_ERR_OOM,
        CMD_SRCH_INC,
        CMD_POP_RD,
        CMD_POP_WR,
        CMD_SPLIT,
        CMD_FB_ENTER,
        CMD_RM_START,
        CMD_RM_RD,
        CMD_RM_NXT,
        CMD_RM_FRD,
        CMD_RM_FWR,
        CMD_MERGE,
        CMD_PUSH,
        CMD_CLR_START,
        CMD_CLR,
        CMD_POP_CALL,
        CMD_OUT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    lsel;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       lv_bad;
        logic       idx_bad;
        logic       srch_over;
        logic       cnt_zero;
        logic       split_more;
        logic       p_over;
        logic       try_merge;
        logic       buddy_match;
        logic       walk_end;
        logic       walk_hit;
        logic       pop_more;
        logic       clr_last;
        logic       out_free;
    } t_dp_stat;

endpackage

[rtl/core/bpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bpa_datapath.sv]
// Datapath of the buddy page allocator: page tables, free lists, working
// registers, configuration and result register. Uses bpa_pkg and bpa_ram.
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_opcode,
    input  logic [LVL_W-1:0]  i_level,
    input  logic [PAGE_W-1:0] i_page_index,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [1:0]        o_status,
    output logic [PAGE_W-1:0] o_block_index,
    output logic [POOL_W-1:0] o_free_pages
);

    logic [LVL_W-1:0]  r_top;
    logic [POOL_W-1:0] r_pool;
    logic [LVL_W-1:0]  top_eff;
    logic [POOL_W-1:0] pool_eff;

    logic [1:0]        r_op;
    logic [LVL_W-1:0]  r_alv;
    logic [LVL_W-1:0]  r_l;
    logic [LVL_W-1:0]  r_flv;
    logic [POOL_W-1:0] r_p;
    logic [PAGE_W-1:0] r_b;
    logic [PAGE_W-1:0] r_cur;
    logic [CNT_W-1:0]  r_i;
    logic [PAGE_W-1:0] r_blk;
    logic [POOL_W-1:0] r_pcur;
    logic [PAGE_W-1:0] r_clr;
    logic [1:0]        r_stat;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt  [LVL_N];
    logic [PAGE_W-1:0] r_head [LVL_N];

    logic              r_mvalid;
    logic [1:0]        r_mstat;
    logic [PAGE_W-1:0] r_mblk;
    logic [POOL_W-1:0] r_mfree;

    logic [LVL_W-1:0]  lvsel;
    logic [CNT_W-1:0]  cnt_sel;
    logic [PAGE_W-1:0] head_sel;
    logic [PAGE_W-1:0] b;
    logic [PAGE_W-1:0] lo;
    logic [PAGE_W-1:0] hi;
    logic [SUM_W-1:0]  delta;
    logic [POOL_W-1:0] span;
    logic              pop_small;

    logic              free_we;
    logic [PAGE_W-1:0] free_waddr;
    logic              free_wdata;
    logic              free_rd;
    logic              lvl_we;
    logic [LVL_W-1:0]  lvl_rd;
    logic              next_we;
    logic [PAGE_W-1:0] next_waddr;
    logic [PAGE_W-1:0] next_wdata;
    logic [PAGE_W-1:0] next_raddr;
    logic [PAGE_W-1:0] next_rd;
    logic              prev_we;
    logic [PAGE_W-1:0] prev_waddr;
    logic [PAGE_W-1:0] prev_wdata;
    logic [PAGE_W-1:0] prev_rd;

    assign top_eff  = (r_top > LVL_W'(LVL_N - 1)) ? LVL_W'(LVL_N - 1) : r_top;
    assign pool_eff = (r_pool > POOL_W'(MAX_PAGES)) ? POOL_W'(MAX_PAGES) : r_pool;

    assign lvsel    = i_cmd.lsel ? r_l : r_flv;
    assign cnt_sel  = (lvsel < LVL_W'(LVL_N)) ? r_cnt[lvsel] : '0;
    assign head_sel = (lvsel < LVL_W'(LVL_N)) ? r_head[lvsel] : '0;
    assign b        = r_p[PAGE_W-1:0] ^ (PAGE_W'(1) << r_flv);
    assign lo       = (r_p[PAGE_W-1:0] < r_b) ? r_p[PAGE_W-1:0] : r_b;
    assign hi       = (r_p[PAGE_W-1:0] < r_b) ? r_b : r_p[PAGE_W-1:0];
    assign delta    = SUM_W'(1) << lvsel;
    assign span     = POOL_W'(1) << top_eff;
    assign pop_small = ((r_pcur & (span - POOL_W'(1))) != '0)
                    || (({1'b0, r_pcur} + {1'b0, span}) > {1'b0, pool_eff});

    assign o_stat.op          = r_op;
    assign o_stat.lv_bad      = r_alv > top_eff;
    assign o_stat.idx_bad     = r_p >= pool_eff;
    assign o_stat.srch_over   = r_l > top_eff;
    assign o_stat.cnt_zero    = cnt_sel == '0;
    assign o_stat.split_more  = r_l > r_alv;
    assign o_stat.p_over      = r_p >= POOL_W'(MAX_PAGES);
    assign o_stat.try_merge   = (r_flv < top_eff) && ({1'b0, b} < pool_eff);
    assign o_stat.buddy_match = free_rd && (lvl_rd == r_flv);
    assign o_stat.walk_end    = r_i >= cnt_sel;
    assign o_stat.walk_hit    = r_cur == r_b;
    assign o_stat.pop_more    = r_pcur < pool_eff;
    assign o_stat.clr_last    = r_clr == PAGE_W'(MAX_PAGES - 1);
    assign o_stat.out_free    = !r_mvalid || i_m_tready;

    always_comb begin
        free_we    = 1'b0;
        free_waddr = r_p[PAGE_W-1:0];
        free_wdata = 1'b0;
        lvl_we     = 1'b0;
        next_we    = 1'b0;
        next_waddr = r_p[PAGE_W-1:0];
        next_wdata = head_sel;
        next_raddr = r_b;
        prev_we    = 1'b0;
        prev_waddr = next_rd;
        prev_wdata = '0;
        unique case (i_cmd.op)
            CMD_POP_RD: begin
                next_raddr = head_sel;
            end
            CMD_POP_WR: begin
                free_we    = 1'b1;
                free_waddr = r_blk;
                prev_we    = cnt_sel > CNT_W'(1);
            end
            CMD_FB_ENTER: begin
                lvl_we = 1'b1;
            end
            CMD_RM_RD: begin
                next_raddr = r_cur;
            end
            CMD_RM_FWR: begin
                free_we    = 1'b1;
                free_waddr = hi;
                free_wdata = 1'b1;
                if (r_i == '0) begin
                    prev_we = cnt_sel > CNT_W'(1);
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                    prev_we    = (r_i + CNT_W'(1)) < cnt_sel;
                    prev_wdata = prev_rd;
                end
            end
            CMD_MERGE: begin
                free_we    = 1'b1;
                free_waddr = lo;
            end
            CMD_PUSH: begin
                free_we    = 1'b1;
                free_wdata = 1'b1;
                if (cnt_sel < CNT_W'(CNT_MAX)) begin
                    next_we    = 1'b1;
                    prev_we    = cnt_sel != '0;
                    prev_waddr = head_sel;
                    prev_wdata = r_p[PAGE_W-1:0];
                end
            end
            CMD_CLR: begin
                free_we    = 1'b1;
                free_waddr = r_clr;
            end
            default: begin
            end
        endcase
    end

    bpa_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_free (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_raddr (b),
        .o_rdata (free_rd)
    );

    bpa_ram #(.WIDTH(LVL_W), .DEPTH(MAX_PAGES)) u_level (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (r_p[PAGE_W-1:0]),
        .i_wdata (r_flv),
        .i_raddr (b),
        .o_rdata (lvl_rd)
    );

    bpa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_next (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (next_raddr),
        .o_rdata (next_rd)
    );

    bpa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_prev (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (r_b),
        .o_rdata (prev_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= LVL_W'(TOP_RST);
            r_pool   <= POOL_W'(MAX_PAGES);
            r_sum    <= '0;
            r_clr    <= '0;
            r_mvalid <= 1'b0;
            for (int k = 0; k < LVL_N; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOP:  r_top  <= i_cfg_data[LVL_W-1:0];
                    CFG_POOL: r_pool <= i_cfg_data[POOL_W-1:0];
                endcase
            end
            if (i_cmd.op == CMD_OUT) begin
                r_mvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (i_cmd.op)
                CMD_POP_WR, CMD_RM_FWR: begin
                    r_cnt[lvsel] <= cnt_sel - CNT_W'(1);
                    r_sum        <= r_sum - delta;
                end
                CMD_PUSH: begin
                    if (cnt_sel < CNT_W'(CNT_MAX)) begin
                        r_cnt[lvsel] <= cnt_sel + CNT_W'(1);
                        r_sum        <= r_sum + delta;
                    end
                end
                CMD_CLR_START: begin
                    r_sum <= '0;
                    r_clr <= '0;
                    for (int k = 0; k < LVL_N; k++) begin
                        r_cnt[k] <= '0;
                    end
                end
                CMD_CLR: begin
                    r_clr <= r_clr + PAGE_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_op   <= i_opcode;
                r_alv  <= i_level;
                r_l    <= i_level;
                r_flv  <= i_level;
                r_p    <= {1'b0, i_page_index};
                r_stat <= ST_OK;
                r_blk  <= '0;
            end
            CMD_ERR_LV:   r_stat <= ST_LEVEL;
            CMD_ERR_IDX:  r_stat <= ST_INDEX;
            CMD_ERR_OOM:  r_stat <= ST_OOM;
            CMD_SRCH_INC: r_l    <= r_l + LVL_W'(1);
            CMD_POP_RD:   r_blk  <= head_sel;
            CMD_POP_WR:   r_head[lvsel] <= next_rd;
            CMD_SPLIT: begin
                r_l   <= r_l - LVL_W'(1);
                r_flv <= r_l - LVL_W'(1);
                r_p   <= {1'b0, r_blk} + (POOL_W'(1) << (r_l - LVL_W'(1)));
            end
            CMD_FB_ENTER: r_b <= b;
            CMD_RM_START: begin
                r_cur <= head_sel;
                r_i   <= '0;
            end
            CMD_RM_NXT: begin
                r_cur <= next_rd;
                r_i   <= r_i + CNT_W'(1);
            end
            CMD_RM_FWR: begin
                if (r_i == '0) begin
                    r_head[lvsel] <= next_rd;
                end
            end
            CMD_MERGE: begin
                r_p   <= {1'b0, lo};
                r_flv <= r_flv + LVL_W'(1);
            end
            CMD_PUSH: begin
                if (cnt_sel < CNT_W'(CNT_MAX)) begin
                    r_head[lvsel] <= r_p[PAGE_W-1:0];
                end
            end
            CMD_CLR_START: r_pcur <= '0;
            CMD_POP_CALL: begin
                r_p <= r_pcur;
                if (pop_small) begin
                    r_flv  <= '0;
                    r_pcur <= r_pcur + POOL_W'(1);
                end else begin
                    r_flv  <= top_eff;
                    r_pcur <= r_pcur + span;
                end
            end
            CMD_OUT: begin
                r_mstat <= r_stat;
                r_mblk  <= r_blk;
                r_mfree <= (r_sum > SUM_W'(OUT_MAX)) ? POOL_W'(OUT_MAX)
                                                     : r_sum[POOL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid    = r_mvalid;
    assign o_status      = r_mstat;
    assign o_block_index = r_mblk;
    assign o_free_pages  = r_mfree;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_POP_WR) |-> (cnt_sel != '0))
        else $error("pop from an empty free list");

    a_unlink_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_RM_FWR) |-> (r_cur == r_b) && (r_i < cnt_sel))
        else $error("unlink without a matching list entry");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_OUT) |-> (!r_mvalid || i_m_tready))
        else $error("result overwritten before transfer");

endmodule

[rtl/core/bpa_ctrl.sv]
// Sequencing controller of the buddy page allocator: walks allocate, free,
// merge, list unlink, populate and clearing sweeps. Uses bpa_pkg.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_SRCH, S_APOP, S_SPLIT, S_F0, S_F1,
        S_RLOOP, S_RNXT, S_RFND, S_MERGE, S_PUSH, S_PLOOP, S_DONE
    } t_state;

    typedef enum logic [1:0] {R_ALLOC, R_FREE, R_POP} t_ret;

    t_state  r_state, n_state;
    t_ret    r_ret, n_ret;
    logic    r_pop, n_pop;
    t_state  ret_state;
    t_cmd_op cmd_op;

    always_comb begin
        unique case (r_ret)
            R_ALLOC: ret_state = S_SPLIT;
            R_FREE:  ret_state = S_DONE;
            default: ret_state = S_PLOOP;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pop   = r_pop;
        cmd_op  = CMD_NOP;
        unique case (r_state)
            S_CLR: begin
                cmd_op = CMD_CLR;
                if (i_stat.clr_last) begin
                    n_state = r_pop ? S_PLOOP : S_IDLE;
                    n_pop   = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd_op  = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.op)
                    OP_ALLOC: begin
                        if (i_stat.lv_bad) begin
                            cmd_op  = CMD_ERR_LV;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end
                    OP_FREE: begin
                        priority if (i_stat.lv_bad) begin
                            cmd_op  = CMD_ERR_LV;
                            n_state = S_DONE;
                        end else if (i_stat.idx_bad) begin
                            cmd_op  = CMD_ERR_IDX;
                            n_state = S_DONE;
                        end else begin
                            n_ret   = R_FREE;
                            n_state = S_F0;
                        end
                    end
                    OP_POPULATE: begin
                        cmd_op  = CMD_CLR_START;
                        n_pop   = 1'b1;
                        n_state = S_CLR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SRCH: begin
                priority if (i_stat.srch_over) begin
                    cmd_op  = CMD_ERR_OOM;
                    n_state = S_DONE;
                end else if (i_stat.cnt_zero) begin
                    cmd_op = CMD_SRCH_INC;
                end else begin
                    cmd_op  = CMD_POP_RD;
                    n_state = S_APOP;
                end
            end
            S_APOP: begin
                cmd_op  = CMD_POP_WR;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_stat.split_more) begin
                    cmd_op  = CMD_SPLIT;
                    n_ret   = R_ALLOC;
                    n_state = S_F0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F0: begin
                if (i_stat.p_over) begin
                    n_state = ret_state;
                end else begin
                    cmd_op  = CMD_FB_ENTER;
                    n_state = i_stat.try_merge ? S_F1 : S_PUSH;
                end
            end
            S_F1: begin
                if (i_stat.buddy_match) begin
                    cmd_op  = CMD_RM_START;
                    n_state = S_RLOOP;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_RLOOP: begin
                priority if (i_stat.walk_end) begin
                    n_state = S_PUSH;
                end else if (i_stat.walk_hit) begin
                    cmd_op  = CMD_RM_FRD;
                    n_state = S_RFND;
                end else begin
                    cmd_op  = CMD_RM_RD;
                    n_state = S_RNXT;
                end
            end
            S_RNXT: begin
                cmd_op  = CMD_RM_NXT;
                n_state = S_RLOOP;
            end
            S_RFND: begin
                cmd_op  = CMD_RM_FWR;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                cmd_op  = CMD_MERGE;
                n_state = S_F0;
            end
            S_PUSH: begin
                cmd_op  = CMD_PUSH;
                n_state = ret_state;
            end
            S_PLOOP: begin
                if (i_stat.pop_more) begin
                    cmd_op  = CMD_POP_CALL;
                    n_ret   = R_POP;
                    n_state = S_F0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd_op  = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= R_FREE;
            r_pop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pop   <= n_pop;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
    assign o_cmd.op   = cmd_op;
    assign o_cmd.lsel = (r_state == S_SRCH) || (r_state == S_APOP);

endmodule

[rtl/core/buddy_page_allocator_core.sv]
// Binary buddy page allocator core over a pool of minimum-size pages.
// Stream request in, one result per request out, plain config write port.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath and bpa_ram.
//
// Requests: s_axis_tuser = opcode (allocate, free, populate), s_axis_tdata
// holds level and page_index. Results: m_axis_tuser = status, m_axis_tdata
// holds block_index and free_pages. One request is in work at a time; the
// next is taken as soon as the previous result sits in the output register.
// Allocate searches the levels upward, pops a block and then makes one
// free-block pass per split; a free makes one free-block pass. A pass
// merges with the buddy while it is free, walking the free list to find
// it, skips the check when no buddy can exist, and then pushes the
// block. Populate first runs a clear sweep over all 1024 entries of the
// free-bit table and then makes one free-block pass per block laid into
// the pool. Reset starts the same clear sweep; s_axis_tready stays low
// until it ends. Config writes are taken at any time and should be made
// while idle. A stalled m_axis_tready holds the result; the core finishes
// at most one more request and then waits.
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,  // level[3:0], page_index[13:4]
    input  logic [1:0]       s_axis_tuser,  // opcode[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // block_index[9:0], free_pages[20:10]
    output logic [1:0]       m_axis_tuser   // status[1:0]
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [PAGE_W-1:0] blk;
    logic [POOL_W-1:0] fpages;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (s_axis_tuser),
        .i_level       (s_axis_tdata[LVL_W-1:0]),
        .i_page_index  (s_axis_tdata[LVL_W+PAGE_W-1:LVL_W]),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_block_index (blk),
        .o_free_pages  (fpages)
    );

    assign m_axis_tdata = {3'b000, fpages, blk};

endmodule
